FILE: hdl/srmq_pkg.sv
// Shared constants, types and helpers for the sparse-table range-minimum core.
package srmq_pkg;

  localparam int DEPTH      = 1024;
  localparam int LEVELS     = 11;
  localparam int DATA_WIDTH = 32;

  // index fields are fixed at 10 bits
  localparam int IDX_W   = 10;
  localparam int DEPTH_W = $clog2(DEPTH + 1);
  localparam int LVL_W   = $clog2(LEVELS);
  localparam int ADDR_W  = $clog2(LEVELS * DEPTH);
  localparam int MEM_DEPTH = LEVELS * DEPTH;

  // highest level the build fills: window must fit in the table
  localparam int FLOOR_LOG2_DEPTH = $clog2(DEPTH + 1) - 1;
  localparam int MAX_LEVEL = (LEVELS - 1 < FLOOR_LOG2_DEPTH) ? LEVELS - 1 : FLOOR_LOG2_DEPTH;

  typedef logic [DATA_WIDTH-1:0] data_t;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_BUILD = 2'd1,
    OP_QUERY = 2'd2,
    OP_NOP   = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BRDA,
    ST_BRDB,
    ST_BWR,
    ST_QLEN,
    ST_QRDA,
    ST_QRDB,
    ST_QOUT
  } state_t;

  // sequencer to datapath controls
  typedef struct packed {
    logic we;
    logic wsel_build;
    logic latch_a;
    logic out_fire;
    logic out_err;
  } ctl_t;

  function automatic logic [ADDR_W-1:0] mem_addr(input logic [LVL_W-1:0] lvl,
                                                 input logic [IDX_W-1:0] idx);
    mem_addr = ADDR_W'(ADDR_W'(lvl) * ADDR_W'(DEPTH)) + ADDR_W'(idx);
  endfunction

  function automatic data_t smin(input data_t a, input data_t b);
    smin = ($signed(b) < $signed(a)) ? b : a;
  endfunction

endpackage

FILE: hdl/sparse_table_range_min_core.sv
// Top level of the sparse-table range-minimum core: table memory and result path.
//
// Usage: drive in_opcode and its fields with start; a word is taken at a
// rising edge where start is high and busy is low.
//   Load  (opcode 0): writes in_elem_value at in_elem_index of the base level
//                     in the accepting cycle; busy stays low, no result.
//   Build (opcode 1): sweeps every higher level, each entry in states BRDA,
//                     BRDB and BWR (two reads of the lower level through the
//                     single read port, one write); level j has
//                     DEPTH - 2^j + 1 entries. Busy is high throughout.
//                     No result.
//   Query (opcode 2): one result word via length/level, two reads on the
//                     one read port, compare and output register; out_valid
//                     pulses for one cycle. A left index above the right
//                     gives range_status 1 from the length step, without
//                     the reads. The next word is taken once busy drops.
//   Opcode 3 is ignored.
// out_valid flags a result for exactly one cycle; the result fields hold
// until the next result and the receiver has no way to stall. Reset returns
// the sequencer to idle and clears out_valid; table contents are not
// cleared, so queries need loads and a build first.
module sparse_table_range_min_core
  import srmq_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_opcode,
  input  logic [IDX_W-1:0]   in_elem_index,
  input  logic signed [31:0] in_elem_value,
  input  logic [IDX_W-1:0]   in_range_left,
  input  logic [IDX_W-1:0]   in_range_right,
  output logic               out_valid,
  output logic signed [31:0] out_range_minimum,
  output logic               out_range_status
);

  ctl_t              ctl;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  data_t             wdata;
  data_t             rdata;
  data_t             a_r;
  data_t             min_val;

  logic               out_valid_r;
  logic signed [31:0] out_min_r;
  logic               out_status_r;

  srmq_seq u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .in_opcode      (in_opcode),
    .in_elem_index  (in_elem_index),
    .in_range_left  (in_range_left),
    .in_range_right (in_range_right),
    .busy           (busy),
    .waddr          (waddr),
    .raddr          (raddr),
    .ctl            (ctl)
  );

  srmq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (MEM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ctl.we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign min_val = smin(a_r, rdata);
  assign wdata   = ctl.wsel_build ? min_val : DATA_WIDTH'(in_elem_value);

  always_ff @(posedge clk) begin
    if (ctl.latch_a) begin
      a_r <= rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl.out_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_fire) begin
      out_min_r    <= ctl.out_err ? '0 : 32'($signed(min_val));
      out_status_r <= ctl.out_err;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_range_minimum = out_min_r;
  assign out_range_status  = out_status_r;

endmodule

FILE: hdl/srmq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module srmq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/srmq_seq.sv
// Sequencer: command decode, build sweep and query address generation.
module srmq_seq
  import srmq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [1:0]        in_opcode,
  input  logic [IDX_W-1:0]  in_elem_index,
  input  logic [IDX_W-1:0]  in_range_left,
  input  logic [IDX_W-1:0]  in_range_right,
  output logic              busy,
  output logic [ADDR_W-1:0] waddr,
  output logic [ADDR_W-1:0] raddr,
  output ctl_t              ctl
);

  state_t             state_r, state_nxt;
  logic [LVL_W-1:0]   lvl_r, lvl_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [IDX_W-1:0]   l_r, l_nxt;
  logic [IDX_W-1:0]   r_r, r_nxt;
  logic [LVL_W-1:0]   k_r, k_nxt;
  logic [IDX_W-1:0]   hi_r, hi_nxt;

  logic               accept;
  logic [DEPTH_W-1:0] last_idx;
  logic [IDX_W-1:0]   half;
  logic [DEPTH_W-1:0] len;
  logic [LVL_W-1:0]   lead;
  logic [IDX_W-1:0]   l_sat, r_sat;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  assign last_idx = DEPTH_W'(DEPTH) - (DEPTH_W'(1) << lvl_r);
  assign half     = IDX_W'(1) << (lvl_r - LVL_W'(1));
  assign len      = DEPTH_W'(r_r) - DEPTH_W'(l_r) + DEPTH_W'(1);

  // query indices past the table clamp to the last entry
  assign l_sat = (DEPTH_W'(in_range_left) >= DEPTH_W'(DEPTH)) ? IDX_W'(DEPTH - 1) : in_range_left;
  assign r_sat = (DEPTH_W'(in_range_right) >= DEPTH_W'(DEPTH)) ? IDX_W'(DEPTH - 1)
                                                               : in_range_right;

  // leading-one detect, clamped to the top level
  always_comb begin
    lead = '0;
    for (int b = 0; b < DEPTH_W; b++) begin
      if (len[b]) begin
        lead = (b > LEVELS - 1) ? LVL_W'(LEVELS - 1) : LVL_W'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      lvl_r   <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      lvl_r   <= lvl_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    l_r  <= l_nxt;
    r_r  <= r_nxt;
    k_r  <= k_nxt;
    hi_r <= hi_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    lvl_nxt   = lvl_r;
    idx_nxt   = idx_r;
    l_nxt     = l_r;
    r_nxt     = r_r;
    k_nxt     = k_r;
    hi_nxt    = hi_r;
    waddr     = mem_addr(lvl_r, idx_r);
    raddr     = mem_addr(lvl_r - LVL_W'(1), idx_r);
    ctl       = '0;

    case (state_r)
      ST_IDLE: begin
        waddr = mem_addr('0, in_elem_index);
        if (accept) begin
          case (opcode_t'(in_opcode))
            OP_LOAD: begin
              ctl.we = (DEPTH_W'(in_elem_index) < DEPTH_W'(DEPTH));
            end
            OP_BUILD: begin
              lvl_nxt   = LVL_W'(1);
              idx_nxt   = '0;
              state_nxt = ST_BRDA;
            end
            OP_QUERY: begin
              l_nxt     = l_sat;
              r_nxt     = r_sat;
              state_nxt = ST_QLEN;
            end
            default: ;
          endcase
        end
      end

      ST_BRDA: begin
        state_nxt = ST_BRDB;
      end

      ST_BRDB: begin
        raddr     = mem_addr(lvl_r - LVL_W'(1), idx_r + half);
        state_nxt = ST_BWR;
      end

      ST_BWR: begin
        ctl.we         = 1'b1;
        ctl.wsel_build = 1'b1;
        if (DEPTH_W'(idx_r) == last_idx) begin
          if (lvl_r == LVL_W'(MAX_LEVEL)) begin
            state_nxt = ST_IDLE;
          end else begin
            lvl_nxt   = lvl_r + LVL_W'(1);
            idx_nxt   = '0;
            state_nxt = ST_BRDA;
          end
        end else begin
          idx_nxt   = idx_r + IDX_W'(1);
          state_nxt = ST_BRDA;
        end
      end

      ST_QLEN: begin
        k_nxt  = lead;
        hi_nxt = IDX_W'(DEPTH_W'(r_r) + DEPTH_W'(1) - (DEPTH_W'(1) << lead));
        if (l_r > r_r) begin
          ctl.out_fire = 1'b1;
          ctl.out_err  = 1'b1;
          state_nxt    = ST_IDLE;
        end else begin
          state_nxt = ST_QRDA;
        end
      end

      ST_QRDA: begin
        raddr     = mem_addr(k_r, l_r);
        state_nxt = ST_QRDB;
      end

      ST_QRDB: begin
        raddr     = mem_addr(k_r, hi_r);
        state_nxt = ST_QOUT;
      end

      ST_QOUT: begin
        ctl.out_fire = 1'b1;
        state_nxt    = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // first read word lands from the RAM read register in the cycle after its address
    ctl.latch_a = (state_r == ST_BRDB) || (state_r == ST_QRDB);
  end

endmodule

FILE: tb/sparse_table_range_min_checker.sv
// Checker for the sparse-table range-minimum core: predicts every query word and compares.
`timescale 1ns / 100ps

module sparse_table_range_min_checker
  import srmq_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         in_opcode,
  input  logic [IDX_W-1:0]   in_elem_index,
  input  logic signed [31:0] in_elem_value,
  input  logic [IDX_W-1:0]   in_range_left,
  input  logic [IDX_W-1:0]   in_range_right,
  input  logic               out_valid,
  input  logic signed [31:0] out_range_minimum,
  input  logic               out_range_status,
  output int                 n_fail,
  output int                 n_pending,
  output int                 n_checked
);

  typedef struct {
    logic [31:0] minimum;
    logic        status;
    int          left;
    int          right;
  } range_answer_t;

  // shadow copy of every level of the table
  data_t         level_tbl [LEVELS][DEPTH];
  range_answer_t expected_minima [$];

  initial begin
    n_fail    = 0;
    n_pending = 0;
    n_checked = 0;
  end

  function automatic data_t lesser(input data_t a, input data_t b);
    return ($signed(a) <= $signed(b)) ? a : b;
  endfunction

  task automatic rebuild_levels();
    int lvl;
    int i;
    int win;
    for (lvl = 1; lvl < LEVELS; lvl++) begin
      win = 1 << lvl;
      if (win > DEPTH) break;
      for (i = 0; i + win <= DEPTH; i++)
        level_tbl[lvl][i] = lesser(level_tbl[lvl-1][i], level_tbl[lvl-1][i + win / 2]);
    end
  endtask

  task automatic predict_query();
    range_answer_t ans;
    int            l;
    int            r;
    int            len;
    int            k;
    data_t         m;
    l = in_range_left;
    r = in_range_right;
    if (l > DEPTH - 1) l = DEPTH - 1;
    if (r > DEPTH - 1) r = DEPTH - 1;
    ans.left  = l;
    ans.right = r;
    if (l > r) begin
      ans.minimum = '0;
      ans.status  = 1'b1;
    end else begin
      len = r - l + 1;
      k = 0;
      while ((len >> (k + 1)) != 0) k++;
      if (k > LEVELS - 1) k = LEVELS - 1;
      // two overlapping windows of 2^k cover the range
      m = lesser(level_tbl[k][l], level_tbl[k][r + 1 - (1 << k)]);
      ans.minimum = 32'($signed(m));
      ans.status  = 1'b0;
    end
    expected_minima.push_back(ans);
  endtask

  task automatic apply_word();
    int idx;
    case (opcode_t'(in_opcode))
      OP_LOAD: begin
        idx = in_elem_index;
        if (idx < DEPTH) level_tbl[0][idx] = data_t'(in_elem_value);
      end
      OP_BUILD: rebuild_levels();
      OP_QUERY: predict_query();
      default: ;
    endcase
  endtask

  task automatic check_result();
    range_answer_t want;
    if (expected_minima.size() == 0) begin
      n_fail++;
      if (n_fail <= 10)
        $display("%0t: unexpected result word: min %0d status %0b", $realtime,
                 out_range_minimum, out_range_status);
    end else begin
      want = expected_minima.pop_front();
      n_checked++;
      if (want.minimum !== out_range_minimum || want.status !== out_range_status) begin
        n_fail++;
        if (n_fail <= 10)
          $display("%0t: query [%0d,%0d] expected min %0d status %0b, got min %0d status %0b",
                   $realtime, want.left, want.right, $signed(want.minimum), want.status,
                   out_range_minimum, out_range_status);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      // a result can only belong to a word taken at an earlier edge
      if (out_valid === 1'b1) check_result();
      if (start === 1'b1 && busy === 1'b0) apply_word();
      n_pending = expected_minima.size();
    end
  end

endmodule

FILE: tb/sparse_table_range_min_core_tb.sv
// Top of the range-minimum core testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module sparse_table_range_min_core_tb;
  import srmq_pkg::*;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         in_opcode = '0;
  logic [IDX_W-1:0]   in_elem_index = '0;
  logic signed [31:0] in_elem_value = '0;
  logic [IDX_W-1:0]   in_range_left = '0;
  logic [IDX_W-1:0]   in_range_right = '0;
  logic               out_valid;
  logic signed [31:0] out_range_minimum;
  logic               out_range_status;

  int n_fail;
  int n_pending;
  int n_checked;

  int n_items  = 0;
  int n_loads  = 0;
  int n_builds = 0;
  int n_queries = 0;
  int n_range_err = 0;
  int n_nops   = 0;
  int burst_left = 0;
  bit built = 1'b0;
  bit loaded [DEPTH];
  int fill_order [DEPTH];

  always #5 clk = ~clk;

  sparse_table_range_min_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_opcode         (in_opcode),
    .in_elem_index     (in_elem_index),
    .in_elem_value     (in_elem_value),
    .in_range_left     (in_range_left),
    .in_range_right    (in_range_right),
    .out_valid         (out_valid),
    .out_range_minimum (out_range_minimum),
    .out_range_status  (out_range_status)
  );

  sparse_table_range_min_checker min_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_opcode         (in_opcode),
    .in_elem_index     (in_elem_index),
    .in_elem_value     (in_elem_value),
    .in_range_left     (in_range_left),
    .in_range_right    (in_range_right),
    .out_valid         (out_valid),
    .out_range_minimum (out_range_minimum),
    .out_range_status  (out_range_status),
    .n_fail            (n_fail),
    .n_pending         (n_pending),
    .n_checked         (n_checked)
  );

  initial begin
    #15000000;
    $display("sparse_table_range_min_core_tb: errors");
    $finish;
  end

  // unused fields of a word carry random bits
  task automatic issue_word(input opcode_t op, input logic [IDX_W-1:0] idx,
                            input logic [31:0] val, input logic [IDX_W-1:0] l,
                            input logic [IDX_W-1:0] r);
    @(negedge clk);
    start          = 1'b1;
    in_opcode      = op;
    in_elem_index  = (op == OP_LOAD) ? idx : IDX_W'($urandom);
    in_elem_value  = (op == OP_LOAD) ? val : $urandom;
    in_range_left  = (op == OP_QUERY) ? l : IDX_W'($urandom);
    in_range_right = (op == OP_QUERY) ? r : IDX_W'($urandom);
    do @(posedge clk); while (busy !== 1'b0);
    case (op)
      OP_LOAD: begin
        n_loads++;
        n_items++;
        loaded[idx] = 1'b1;
      end
      OP_BUILD: begin
        n_builds++;
        n_items++;
        built = 1'b1;
      end
      OP_QUERY: begin
        n_queries++;
        n_items++;
        if (l > r) n_range_err++;
      end
      default: n_nops++;
    endcase
  endtask

  task automatic idle_gap();
    int sel;
    int n;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    if ($urandom_range(0, 99) < 2) burst_left = $urandom_range(16, 64);
    sel = $urandom_range(0, 99);
    if (sel < 45)      n = 0;
    else if (sel < 80) n = $urandom_range(1, 3);
    else if (sel < 96) n = $urandom_range(4, 12);
    else               n = $urandom_range(20, 80);
    if (n > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  function automatic logic [31:0] pick_value();
    int sel;
    sel = $urandom_range(0, 15);
    case (sel)
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'($urandom_range(0, 2)) - 32'd1;
      3, 4:    return 32'($urandom_range(0, 200)) - 32'd100;
      default: return $urandom;
    endcase
  endfunction

  task automatic rand_query();
    int l;
    int r;
    int len;
    int sel;
    int tries;
    sel = $urandom_range(0, 99);
    if (sel < 6 || (!built && sel < 25)) begin
      l = $urandom_range(1, DEPTH - 1);
      r = $urandom_range(0, l - 1);
    end else if (!built) begin
      // before a build only single-element windows read written entries
      l = $urandom_range(0, DEPTH - 1);
      for (tries = 0; tries < 20 && !loaded[l]; tries++) l = $urandom_range(0, DEPTH - 1);
      if (!loaded[l]) l = 0;
      r = l;
    end else begin
      if (sel < 50)      len = $urandom_range(1, 16);
      else if (sel < 75) len = $urandom_range(1, DEPTH);
      else if (sel < 90) len = (1 << $urandom_range(0, 10)) + $urandom_range(0, 2) - 1;
      else               len = $urandom_range(DEPTH - 24, DEPTH);
      if (len < 1) len = 1;
      if (len > DEPTH) len = DEPTH;
      l = $urandom_range(0, DEPTH - len);
      r = l + len - 1;
    end
    issue_word(OP_QUERY, '0, '0, IDX_W'(l), IDX_W'(r));
  endtask

  initial begin
    int i;
    int j;
    int tmp;
    int sel;
    int next_build;
    int guard;

    for (i = 0; i < DEPTH; i++) begin
      fill_order[i] = i;
      loaded[i] = 1'b0;
    end
    for (i = DEPTH - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = fill_order[i];
      fill_order[i] = fill_order[j];
      fill_order[j] = tmp;
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // extremes at both ends of the base level, single-element and reversed ranges
    issue_word(OP_NOP, '0, '0, '0, '0);
    issue_word(OP_LOAD, 10'd0, 32'h8000_0000, '0, '0);
    issue_word(OP_LOAD, 10'd1023, 32'h7fff_ffff, '0, '0);
    issue_word(OP_LOAD, 10'd1, 32'h0000_0000, '0, '0);
    issue_word(OP_LOAD, 10'd1022, 32'hffff_ffff, '0, '0);
    issue_word(OP_LOAD, 10'd512, 32'h0000_0001, '0, '0);
    issue_word(OP_QUERY, '0, '0, 10'd0, 10'd0);
    issue_word(OP_QUERY, '0, '0, 10'd1023, 10'd1023);
    issue_word(OP_QUERY, '0, '0, 10'd1, 10'd1);
    issue_word(OP_QUERY, '0, '0, 10'd1022, 10'd1022);
    issue_word(OP_QUERY, '0, '0, 10'd512, 10'd512);
    issue_word(OP_QUERY, '0, '0, 10'd1023, 10'd0);
    issue_word(OP_QUERY, '0, '0, 10'd1, 10'd0);
    issue_word(OP_QUERY, '0, '0, 10'd512, 10'd511);
    issue_word(OP_NOP, '0, '0, '0, '0);

    // fill the whole base level in random order before the first build
    for (i = 0; i < DEPTH; i++) begin
      if (!loaded[fill_order[i]]) begin
        issue_word(OP_LOAD, IDX_W'(fill_order[i]), pick_value(), '0, '0);
        idle_gap();
      end
      sel = $urandom_range(0, 99);
      if (sel < 12) begin
        rand_query();
        idle_gap();
      end else if (sel < 14) begin
        issue_word(OP_NOP, '0, '0, '0, '0);
      end
    end
    issue_word(OP_BUILD, '0, '0, '0, '0);

    // full table, halves, and windows straddling the middle and both ends
    issue_word(OP_QUERY, '0, '0, 10'd0, 10'd1023);
    issue_word(OP_QUERY, '0, '0, 10'd0, 10'd1022);
    issue_word(OP_QUERY, '0, '0, 10'd1, 10'd1023);
    issue_word(OP_QUERY, '0, '0, 10'd0, 10'd511);
    issue_word(OP_QUERY, '0, '0, 10'd512, 10'd1023);
    issue_word(OP_QUERY, '0, '0, 10'd0, 10'd1);
    issue_word(OP_QUERY, '0, '0, 10'd1022, 10'd1023);
    issue_word(OP_QUERY, '0, '0, 10'd511, 10'd512);
    issue_word(OP_QUERY, '0, '0, 10'd0, 10'd767);

    next_build = n_items + $urandom_range(150, 300);
    while (n_items < 1800) begin
      if (n_items >= next_build) begin
        issue_word(OP_BUILD, '0, '0, '0, '0);
        next_build = n_items + $urandom_range(150, 300);
      end else begin
        sel = $urandom_range(0, 99);
        // loads after a build leave the upper levels stale but still written
        if (sel < 3)       issue_word(OP_NOP, '0, '0, '0, '0);
        else if (sel < 20) issue_word(OP_LOAD, IDX_W'($urandom), pick_value(), '0, '0);
        else               rand_query();
      end
      idle_gap();
    end

    @(negedge clk);
    start = 1'b0;
    guard = 0;
    while ((n_pending != 0 || busy !== 1'b0) && guard < 40000) begin
      @(negedge clk);
      guard++;
    end
    repeat (10) @(negedge clk);

    if (n_pending != 0) $display("%0d expected results never arrived", n_pending);
    $display("run covered %0d loads, %0d builds, %0d queries (%0d reversed), %0d ignored words",
             n_loads, n_builds, n_queries, n_range_err, n_nops);
    $display("%0d result words compared, %0d failures", n_checked, n_fail);
    if (n_fail == 0 && n_pending == 0) begin
      $display("sparse_table_range_min_core_tb: clean");
    end else begin
      $display("sparse_table_range_min_core_tb: errors");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/srmq_pkg.sv
hdl/srmq_ram.sv
hdl/srmq_seq.sv
hdl/sparse_table_range_min_core.sv
tb/sparse_table_range_min_checker.sv
tb/sparse_table_range_min_core_tb.sv
